/* rtl/bmtb_pkg.sv */
// bmtb_pkg: shared types, constants and the led pattern decode for the
// button mode toggle block; no dependencies
`timescale 1ns / 1ps

package bmtb_pkg;

  localparam int unsigned PeriodW = 8;
  localparam int unsigned PressW  = 12;
  localparam int unsigned PhaseW  = 10;
  localparam int unsigned IndexW  = 2;
  localparam int unsigned DataW   = 12;

  localparam logic [PeriodW-1:0] SINCE_MAX      = 8'd255;
  localparam logic [PressW-1:0]  HELD_MAX       = 12'd4095;
  localparam logic [PhaseW-1:0]  PHASE_LAST     = 10'd999;
  localparam logic [PhaseW-1:0]  SLOW_ON_END    = 10'd500;
  localparam logic [PhaseW-1:0]  FAST_ON1_END   = 10'd50;
  localparam logic [PhaseW-1:0]  FAST_ON2_START = 10'd150;
  localparam logic [PhaseW-1:0]  FAST_ON2_END   = 10'd200;

  localparam logic [PeriodW-1:0] SAMPLE_PERIOD_RESET = 8'd20;
  localparam logic [PressW-1:0]  MIN_PRESS_RESET     = 12'd50;
  localparam logic [PressW-1:0]  MAX_PRESS_RESET     = 12'd3000;

  localparam logic [IndexW-1:0] REG_SAMPLE_PERIOD = 2'd0;
  localparam logic [IndexW-1:0] REG_MIN_PRESS     = 2'd1;
  localparam logic [IndexW-1:0] REG_MAX_PRESS     = 2'd2;

  localparam logic KIND_TICK     = 1'b0;
  localparam logic KIND_SET_MODE = 1'b1;

  typedef struct packed {
    logic kind;
    logic button_level;
    logic requested_mode;
  } item_t;

  typedef struct packed {
    logic mode;
    logic led_on;
    logic mode_changed;
  } result_t;

  typedef struct packed {
    logic [PeriodW-1:0] sample_period_ms;
    logic [PressW-1:0]  min_press_ms;
    logic [PressW-1:0]  max_press_ms;
  } cfg_t;

  function automatic logic led_level(input logic mode, input logic [PhaseW-1:0] phase);
    logic lvl;
    if (!mode) begin
      lvl = (phase < SLOW_ON_END);
    end else begin
      lvl = (phase < FAST_ON1_END) || ((phase >= FAST_ON2_START) && (phase < FAST_ON2_END));
    end
    return lvl;
  endfunction

endpackage

/* rtl/bmtb_press.sv */
// bmtb_press: button sampler and held-time qualifier
// depends on bmtb_pkg
`timescale 1ns / 1ps

module bmtb_press (
  input  logic          clk,
  input  logic          rst,
  input  bmtb_pkg::cfg_t cfg,
  input  logic          tick,
  input  logic          button_level,
  output logic          toggle
);
  import bmtb_pkg::*;

  logic [PeriodW-1:0] ticks_since_sample;
  logic [PeriodW-1:0] ticks_since_sample_next;
  logic               button_held;
  logic               button_held_next;
  logic [PressW-1:0]  held_time;
  logic [PressW-1:0]  held_time_next;
  logic [PressW-1:0]  held_base;
  logic               sample;
  logic               press;
  logic               release_seen;

  always_comb begin
    sample       = (ticks_since_sample >= cfg.sample_period_ms);
    press        = sample && button_level && !button_held;
    release_seen = sample && !button_level && button_held;
    toggle       = release_seen && (held_time >= cfg.min_press_ms) &&
                   (held_time < cfg.max_press_ms);

    if (press) begin
      button_held_next = 1'b1;
    end else if (release_seen) begin
      button_held_next = 1'b0;
    end else begin
      button_held_next = button_held;
    end

    held_base = press ? '0 : held_time;
    if (button_held_next && (held_base < HELD_MAX)) begin
      held_time_next = held_base + 1'b1;
    end else begin
      held_time_next = held_base;
    end

    // restart at one on sample, then count up with saturation
    if (sample) begin
      ticks_since_sample_next = PeriodW'(1);
    end else if (ticks_since_sample < SINCE_MAX) begin
      ticks_since_sample_next = ticks_since_sample + 1'b1;
    end else begin
      ticks_since_sample_next = ticks_since_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_since_sample <= '0;
      button_held        <= 1'b0;
      held_time          <= '0;
    end else if (tick) begin
      ticks_since_sample <= ticks_since_sample_next;
      button_held        <= button_held_next;
      held_time          <= held_time_next;
    end
  end

endmodule

/* rtl/button_mode_toggle_with_blink_core.sv */
// button_mode_toggle_with_blink_core: top level with mode flag, blink phase,
// configuration registers and result register; uses bmtb_pkg and bmtb_press
`timescale 1ns / 1ps

// Takes one item per clock while item_stall is low and returns one result
// per item, in the cycle after acceptance, from a single result register.
// Tick items (kind 0) advance a 1 ms time base: the button is sampled every
// sample_period_ms ticks, and a press held for a time in [min_press_ms,
// max_press_ms) toggles the mode at its release sample. Set-mode items
// (kind 1) force the mode without moving time. led_on follows a 1000-tick
// phase: mode 0 is a 500/500 blink, mode 1 a double blink. item_stall rises
// only while the result register holds a result that the downstream side
// stalls, so unstalled the rate is one item per cycle. Configuration writes
// are always ready and are meant to be made only while the block is idle;
// writes to an index beyond the third register are ignored.
module button_mode_toggle_with_blink_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  bmtb_pkg::item_t                 item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output bmtb_pkg::result_t               result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bmtb_pkg::IndexW-1:0]     cfg_index,
  input  logic [bmtb_pkg::DataW-1:0]      cfg_data
);
  import bmtb_pkg::*;

  cfg_t              cfg;
  logic              mode;
  logic              mode_next;
  logic [PhaseW-1:0] blink_phase;
  logic [PhaseW-1:0] blink_phase_next;
  logic              accept;
  logic              tick;
  logic              toggle;
  result_t           result_next;

  assign cfg_ready  = 1'b1;
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;
  assign tick       = accept && (item.kind == KIND_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_period_ms <= SAMPLE_PERIOD_RESET;
      cfg.min_press_ms     <= MIN_PRESS_RESET;
      cfg.max_press_ms     <= MAX_PRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SAMPLE_PERIOD: cfg.sample_period_ms <= cfg_data[PeriodW-1:0];
        REG_MIN_PRESS:     cfg.min_press_ms     <= cfg_data[PressW-1:0];
        REG_MAX_PRESS:     cfg.max_press_ms     <= cfg_data[PressW-1:0];
        default: ;
      endcase
    end
  end

  bmtb_press u_press (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .tick         (tick),
    .button_level (item.button_level),
    .toggle       (toggle)
  );

  always_comb begin
    if (item.kind == KIND_SET_MODE) begin
      mode_next        = item.requested_mode;
      blink_phase_next = blink_phase;
    end else begin
      mode_next        = mode ^ toggle;
      blink_phase_next = (blink_phase == PHASE_LAST) ? '0 : blink_phase + 1'b1;
    end
    result_next.mode         = mode_next;
    result_next.led_on       = led_level(mode_next, blink_phase);
    result_next.mode_changed = (mode_next != mode);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= 1'b0;
      blink_phase  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        mode         <= mode_next;
        blink_phase  <= blink_phase_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    blink_phase <= PHASE_LAST)
    else $error("blink phase out of range");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted transaction produced no result");

  a_result_mode_current: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.mode == mode))
    else $error("result mode disagrees with mode flag");

  a_setmode_same_no_change: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.kind == KIND_SET_MODE) && (item.requested_mode == mode))
      |=> !result.mode_changed)
    else $error("set-mode to current mode reported a change");

endmodule
